FILE: hw/rtl/rlec_pkg.sv
// Shared types and constants for the cumulative run-length encoder.
// No dependencies; imported by every module of the block but rlec_queue.
`timescale 1ns / 1ps

package rlec_pkg;

  localparam int unsigned IndexWidthDef = 32;
  localparam int unsigned QueueDepthDef = 4;
  localparam logic [7:0]  MaxRunReset   = 8'd8;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_text;
  } rlec_in_t;

  typedef struct packed {
    logic [7:0]  run_symbol;
    logic [7:0]  run_length;
    logic [7:0]  cumulative_end;
    logic [31:0] run_index;
    logic        final_run;
  } rlec_out_t;

  // Runs that one input item closes: an ordinary closed run and/or the final run.
  typedef struct packed {
    logic       close_valid;
    logic [7:0] close_symbol;
    logic [7:0] close_length;
    logic       final_valid;
    logic [7:0] final_symbol;
    logic [7:0] final_length;
  } rlec_rec_t;

endpackage

FILE: hw/rtl/rlec_queue.sv
// Small flop-based FIFO between the front and back of the encoder.
// Depends on nothing but its type and depth parameters.
`timescale 1ns / 1ps

module rlec_queue #(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  item_t wr_data_i,
  output logic  full_o,
  input  logic  rd_i,
  output item_t rd_data_o,
  output logic  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  item_t         mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: hw/rtl/rlec_front.sv
// Front end: takes text bytes, tracks the open run, and queues closed runs.
// Depends on rlec_pkg.
`timescale 1ns / 1ps

module rlec_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                accept_i,
  input  rlec_pkg::rlec_in_t  item_i,
  output logic                rec_push_o,
  output rlec_pkg::rlec_rec_t rec_o
);
  import rlec_pkg::*;

  logic       cfg_we;
  logic [7:0] max_len_q;
  logic       run_open_q, run_open_d;
  logic [7:0] sym_q, sym_d, len_q, len_d;
  rlec_rec_t  rec;

  assign cfg_we = cfg_valid_i;

  always_comb begin
    rec        = '0;
    run_open_d = run_open_q;
    sym_d      = sym_q;
    len_d      = len_q;
    if (!run_open_q) begin
      run_open_d = 1'b1;
      sym_d      = item_i.symbol;
      len_d      = 8'd1;
    end else if (item_i.symbol == sym_q && len_q < max_len_q) begin
      len_d = len_q + 8'd1;
    end else begin
      rec.close_valid  = 1'b1;
      rec.close_symbol = sym_q;
      rec.close_length = len_q;
      sym_d            = item_i.symbol;
      len_d            = 8'd1;
    end
    if (item_i.end_of_text) begin
      rec.final_valid  = 1'b1;
      rec.final_symbol = sym_d;
      rec.final_length = len_d;
      run_open_d       = 1'b0;
      sym_d            = '0;
      len_d            = '0;
    end
  end

  assign rec_o      = rec;
  assign rec_push_o = accept_i && (rec.close_valid || rec.final_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= MaxRunReset;
      run_open_q <= 1'b0;
      sym_q      <= '0;
      len_q      <= '0;
    end else begin
      if (cfg_we) begin
        max_len_q <= cfg_data_i;
      end
      if (accept_i) begin
        run_open_q <= run_open_d;
        sym_q      <= sym_d;
        len_q      <= len_d;
      end
    end
  end

endmodule

FILE: hw/rtl/rlec_back.sv
// Back end: expands queued runs into results with running end and index.
// Depends on rlec_pkg.
`timescale 1ns / 1ps

module rlec_back #(
  parameter int unsigned INDEX_WIDTH = rlec_pkg::IndexWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rlec_pkg::rlec_rec_t rec_i,
  input  logic                rec_empty_i,
  output logic                rec_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output rlec_pkg::rlec_out_t result_o
);
  import rlec_pkg::*;

  logic                   out_valid_q;
  rlec_out_t              out_q;
  logic                   second_q;
  logic [7:0]             total_q;
  logic [INDEX_WIDTH-1:0] count_q;
  logic [INDEX_WIDTH+31:0] count_ext;
  logic                   load, do_close;
  logic [7:0]             sel_sym, sel_len, sum;

  assign empty_o   = !out_valid_q;
  assign result_o  = out_q;
  assign load      = (!out_valid_q || pop_i) && !rec_empty_i;
  assign do_close  = rec_i.close_valid && !second_q;
  assign sel_sym   = do_close ? rec_i.close_symbol : rec_i.final_symbol;
  assign sel_len   = do_close ? rec_i.close_length : rec_i.final_length;
  assign sum       = total_q + sel_len;
  assign count_ext = {32'd0, count_q};
  assign rec_pop_o = load && !(do_close && rec_i.final_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
      total_q     <= '0;
      count_q     <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        if (do_close) begin
          total_q  <= sum;
          second_q <= rec_i.final_valid;
          if (count_q != '1) begin
            count_q <= count_q + INDEX_WIDTH'(1);
          end
        end else begin
          total_q  <= '0;
          count_q  <= '0;
          second_q <= 1'b0;
        end
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.run_symbol     <= sel_sym;
      out_q.run_length     <= sel_len;
      out_q.cumulative_end <= sum;
      out_q.run_index      <= count_ext[31:0];
      out_q.final_run      <= !do_close;
    end
  end

endmodule

FILE: hw/rtl/run_length_encoder_cumulative_unit.sv
// Top level of the cumulative run-length encoder: front, run queue, back.
// Depends on rlec_pkg, rlec_front, rlec_queue, rlec_back.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------
//   input    | in        | push / full           | item_i   (rlec_in_t)
//   result   | out       | pop / empty           | result_o (rlec_out_t)
//   config   | in        | cfg_valid_i / cfg_ready_o | cfg_data_i (max run length)
//
// One byte is accepted per cycle unless the run queue is full; a byte that
// closes a run or ends the text writes its record to the run queue as it is
// accepted. Results leave the back end's output register one per cycle while
// pop is held; a byte that closes a run and ends the text yields two results.
// Reset is asynchronous; afterwards max run length is 8 and no run is open.
// full follows the run queue only; a stalled result side fills it first.
`timescale 1ns / 1ps

module run_length_encoder_cumulative_unit #(
  parameter int unsigned INDEX_WIDTH = rlec_pkg::IndexWidthDef,
  parameter int unsigned QUEUE_DEPTH = rlec_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  rlec_pkg::rlec_in_t  item_i,
  output logic                empty,
  input  logic                pop,
  output rlec_pkg::rlec_out_t result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);
  import rlec_pkg::*;

  logic      accept, rec_push, rec_pop, rec_full, rec_empty;
  rlec_rec_t rec_wr, rec_rd;

  assign cfg_ready_o = 1'b1;
  assign full        = rec_full;
  assign accept      = push && !rec_full;

  rlec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (item_i),
    .rec_push_o  (rec_push),
    .rec_o       (rec_wr)
  );

  rlec_queue #(
    .item_t (rlec_rec_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rec_push),
    .wr_data_i (rec_wr),
    .full_o    (rec_full),
    .rd_i      (rec_pop),
    .rd_data_o (rec_rd),
    .empty_o   (rec_empty)
  );

  rlec_back #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec_rd),
    .rec_empty_i (rec_empty),
    .rec_pop_o   (rec_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

FILE: hw/rtl/rlec_checker.sv
// Port-level checks for the cumulative run-length encoder, bound to the top.
// Depends on rlec_pkg and run_length_encoder_cumulative_unit.
`timescale 1ns / 1ps

module rlec_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input rlec_pkg::rlec_out_t result_o
);
  import rlec_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result changed while waiting");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.run_length != 8'd0))
    else $error("zero run length");

  a_index_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && result_o.final_run) |=> (empty || result_o.run_index == 32'd0))
    else $error("run index not restarted after final run");

  a_cum_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !result_o.final_run) |=>
      (empty || result_o.cumulative_end ==
        8'($past(result_o.cumulative_end) + result_o.run_length)))
    else $error("cumulative end mismatch");

endmodule

bind run_length_encoder_cumulative_unit rlec_checker u_rlec_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

FILE: dv/run_length_encoder_cumulative_unit_tb.sv
// Self-checking testbench for run_length_encoder_cumulative_unit: queued byte driver,
// result monitor and an in-bench run predictor with scoreboard.
// Depends on rlec_pkg and the RTL of the block.
`timescale 1ns / 1ps

module run_length_encoder_cumulative_unit_tb;
  import rlec_pkg::*;

  localparam int QuietLimit = 1000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  rlec_in_t   item_i      = '0;
  logic       empty;
  logic       pop         = 1'b0;
  rlec_out_t  result_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i  = '0;

  run_length_encoder_cumulative_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stimulus and expectations
  rlec_in_t  bytes_q[$];
  rlec_out_t runs_due[$];

  int idle_pct  = 20;
  bit calm      = 1'b0;
  int push_hold = 0;
  int pop_hold  = 0;

  // Predictor state
  logic [7:0]  cap       = MaxRunReset;
  logic        run_live  = 1'b0;
  logic [7:0]  live_sym  = '0;
  logic [7:0]  live_len  = '0;
  logic [7:0]  end_pos   = '0;
  logic [31:0] run_count = '0;

  int errs       = 0;
  int bytes_in   = 0;
  int runs_seen  = 0;
  int texts_done = 0;
  int caps_used  = 1;
  int quiet      = 0;

  function automatic void close_run(input logic last);
    rlec_out_t r;
    end_pos          = end_pos + live_len;
    r.run_symbol     = live_sym;
    r.run_length     = live_len;
    r.cumulative_end = end_pos;
    r.run_index      = run_count;
    r.final_run      = last;
    runs_due.push_back(r);
    if (run_count != '1) run_count++;
  endfunction

  function automatic void encode_byte(input rlec_in_t b);
    if (!run_live) begin
      run_live = 1'b1;
      live_sym = b.symbol;
      live_len = 8'd1;
    end else if (b.symbol == live_sym && live_len < cap) begin
      live_len++;
    end else begin
      close_run(1'b0);
      live_sym = b.symbol;
      live_len = 8'd1;
    end
    if (b.end_of_text) begin
      close_run(1'b1);
      run_live  = 1'b0;
      live_sym  = '0;
      live_len  = '0;
      end_pos   = '0;
      run_count = '0;
      texts_done++;
    end
  endfunction

  function automatic void check_run(input rlec_out_t got);
    rlec_out_t want;
    runs_seen++;
    if (runs_due.size() == 0) begin
      $error("unexpected run: symbol %0h length %0d", got.run_symbol, got.run_length);
      errs++;
      return;
    end
    want = runs_due.pop_front();
    if (got.run_symbol !== want.run_symbol) begin
      $error("run_symbol: expected %0h, got %0h", want.run_symbol, got.run_symbol);
      errs++;
    end
    if (got.run_length !== want.run_length) begin
      $error("run_length: expected %0d, got %0d", want.run_length, got.run_length);
      errs++;
    end
    if (got.cumulative_end !== want.cumulative_end) begin
      $error("cumulative_end: expected %0d, got %0d", want.cumulative_end,
             got.cumulative_end);
      errs++;
    end
    if (got.run_index !== want.run_index) begin
      $error("run_index: expected %0d, got %0d", want.run_index, got.run_index);
      errs++;
    end
    if (got.final_run !== want.final_run) begin
      $error("final_run: expected %0b, got %0b", want.final_run, got.final_run);
      errs++;
    end
  endfunction

  // Byte driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!push || !full) begin
        if (push_hold > 0) begin
          push_hold--;
          push <= 1'b0;
        end else if (!calm && bytes_q.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
          push_hold = $urandom_range(0, 4);
          push <= 1'b0;
        end else if (bytes_q.size() != 0) begin
          item_i <= bytes_q.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result side stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_hold > 0) begin
        pop_hold--;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        pop_hold = $urandom_range(1, 5);
      end
      pop <= calm || (pop_hold == 0);
    end
  end

  // Monitor, prediction and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_run(result_o);
      if (push && !full) begin
        encode_byte(item_i);
        bytes_in++;
      end
      if (cfg_valid_i && cfg_ready_o) cap = cfg_data_i;
      if ((pop && !empty) || (push && !full) || (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) begin
        $display("timeout: no item moved for %0d cycles", QuietLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic add_byte(input logic [7:0] sym, input logic eot);
    rlec_in_t b;
    b.symbol      = sym;
    b.end_of_text = eot;
    bytes_q.push_back(b);
  endtask

  // Texts of runs: small alphabets give long runs, full alphabet gives noise.
  task automatic queue_texts(input int n_items, input bit long_runs);
    int left;
    int len;
    int span;
    int base;
    int run;
    int k;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, long_runs ? 400 : 24);
      if (len > left) len = left;
      case ($urandom_range(0, 3))
        0: span = 0;
        1: span = 1;
        2: span = 3;
        default: span = 255;
      endcase
      base = $urandom_range(0, 255);
      run = 0;
      for (k = 0; k < len; k++) begin
        if (run == 0) begin
          run = long_runs ? $urandom_range(1, 300) :
                (span == 255) ? $urandom_range(1, 2) : $urandom_range(1, 10);
          base = (base + $urandom_range(0, span)) & 8'hFF;
        end
        add_byte(base[7:0], k == len - 1);
        run--;
      end
      left -= len;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (bytes_q.size() != 0 || push || runs_due.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cap(input logic [7:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    caps_used++;
  endtask

  task automatic run_phase(input logic [7:0] new_cap, input int n_items,
                           input bit long_runs, input int pct);
    write_cap(new_cap);
    @(negedge clk_i);
    idle_pct = pct;
    queue_texts(n_items, long_runs);
  endtask

  initial begin
    int k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single-byte text
    add_byte(8'h00, 1'b1);
    // run hits the cap of 8, then the ninth byte both closes it and ends the text
    for (k = 0; k < 9; k++) add_byte(8'hFF, k == 8);
    // symbol change on the final byte
    add_byte(8'h55, 1'b0);
    add_byte(8'hAA, 1'b1);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h01, 1'b1);
    queue_texts(185, 1'b0);

    run_phase(8'd1, 150, 1'b0, 20);
    run_phase(8'd255, 300, 1'b1, 30);
    run_phase(8'd0, 100, 1'b0, 50);
    run_phase(8'($urandom_range(2, 254)), 150, 1'b0, 0);
    run_phase(8'($urandom_range(2, 254)), 150, 1'b0, 50);
    run_phase(8'($urandom_range(2, 254)), 150, 1'b0, 20);
    @(negedge clk_i);
    calm = 1'b1;
    run_phase(8'd3, 150, 1'b0, 0);

    wait_drained();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    if (runs_due.size() != 0) begin
      $error("%0d expected runs never arrived", runs_due.size());
      errs++;
    end
    $display("encoded %0d bytes in %0d texts under %0d run caps", bytes_in, texts_done,
             caps_used);
    $display("checked %0d runs, %0d field errors", runs_seen, errs);
    if (errs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
